/* rtl/core/lcar_pkg.sv */
// Shared constants, codes and types of the load-cell converter reader.
package lcar_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int SUM_W       = 32;
    localparam int CNT_W       = 8;
    localparam int DIVISOR_W   = CNT_W + 1;
    localparam int TMO_W       = 24;
    localparam int AVG_W       = 24;
    localparam int NET_W       = AVG_W + 1;
    localparam int BITC_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 56;
    localparam int OUT_USER_W  = 1;

    localparam logic [1:0] MODE_TARE    = 2'd1;
    localparam logic [1:0] MODE_MEASURE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TARE_SAMPLES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT   = 2'd2;

    localparam logic [CNT_W-1:0] TARE_SAMPLES_RST    = 8'd10;
    localparam logic [CNT_W-1:0] MEASURE_SAMPLES_RST = 8'd5;
    localparam logic [TMO_W-1:0] READY_TIMEOUT_RST   = 24'd1000000;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [AVG_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/core/lcar_div.sv */
// Bit-serial signed divider that forms the run average, truncating toward zero.
module lcar_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcar_pkg::t_div_req i_req,
    output lcar_pkg::t_div_rsp o_rsp
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } t_dstate;

    t_dstate                          r_state;
    logic [lcar_pkg::SUM_W-1:0]       r_acc;
    logic [lcar_pkg::DIVISOR_W-1:0]   r_rem;
    logic [lcar_pkg::DIVISOR_W-1:0]   r_den;
    logic                             r_neg;
    logic [4:0]                       r_cnt;
    logic                             r_done;
    logic [lcar_pkg::AVG_W-1:0]       r_quot;

    logic [lcar_pkg::DIVISOR_W:0]     w_trial;
    logic                             w_ge;
    logic [lcar_pkg::DIVISOR_W-1:0]   n_rem;
    logic [lcar_pkg::DIVISOR_W:0]     w_diff;

    always_comb begin
        w_trial = {r_rem, r_acc[lcar_pkg::SUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[lcar_pkg::DIVISOR_W-1:0] : w_trial[lcar_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                D_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_acc   <= i_req.dividend[lcar_pkg::SUM_W-1] ?
                                   (~i_req.dividend + 1'b1) : i_req.dividend;
                        r_neg   <= i_req.dividend[lcar_pkg::SUM_W-1];
                        r_den   <= i_req.divisor;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= n_rem;
                    r_acc <= {r_acc[lcar_pkg::SUM_W-2:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(lcar_pkg::SUM_W - 1)) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    r_quot  <= r_neg ? (~r_acc[lcar_pkg::AVG_W-1:0] + 1'b1)
                                     : r_acc[lcar_pkg::AVG_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot;

endmodule

/* rtl/core/load_cell_adc_reader_top.sv */
// Load-cell converter serial reader: tick sequencer, averaging, tare and output stage.
//
// Each request on the s_axis channel is one time-base tick: tuser carries the mode
// (plain tick, start tare run, start measurement run) and tdata bit 0 the sampled
// data-pin level. Every tick yields exactly one result on m_axis with the serial
// clock level to drive and the run status flags; a run that finishes also carries
// the average and, for measurement runs, the net value against the stored tare.
// A plain tick's result is registered and shows in the cycle after the tick is taken.
// The tick that completes a run gets its result from the bit-serial divider (load,
// one quotient bit per cycle over the 32-bit sum, sign fix); no tick is taken meanwhile.
// The result sits in an output register: a new tick is taken while the previous
// result is being taken in the same cycle, and when the receiver stalls the result
// holds and s_axis_tready stays low until it is taken. The configuration port
// writes the sample counts and the ready timeout; the user must write it only while
// the block is idle; the block does not enforce this. Synchronous active-low reset
// returns the sequencer to idle, clears the tare, loads the default register values.
module load_cell_adc_reader_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lcar_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] data_level
    input  logic [lcar_pkg::IN_USER_W-1:0]      s_axis_tuser,  // [1:0] mode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] clock_level, [1] busy_res, [2] done_res, [3] timed_out,
    // [27:4] average, [52:28] net, [55:53] zero
    output logic [lcar_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [lcar_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // [0] was_tare
    input  logic                                i_cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_SAMPLE
    } t_phase;

    t_phase                              r_phase;
    logic [lcar_pkg::BITC_W-1:0]         r_bitc;
    logic [lcar_pkg::SAMPLE_BITS-1:0]    r_shift;
    logic [lcar_pkg::SUM_W-1:0]          r_sum;
    logic [lcar_pkg::CNT_W-1:0]          r_cnt;
    logic [lcar_pkg::TMO_W-1:0]          r_wait;
    logic [lcar_pkg::AVG_W-1:0]          r_tare;
    logic                                r_doing_tare;
    logic                                r_div_busy;

    logic [lcar_pkg::CNT_W-1:0]          r_tare_samples;
    logic [lcar_pkg::CNT_W-1:0]          r_meas_samples;
    logic [lcar_pkg::TMO_W-1:0]          r_timeout;

    logic                                r_out_valid;
    logic [lcar_pkg::OUT_DATA_W-1:0]     r_out_data;
    logic                                r_out_user;

    t_phase                              n_phase;
    logic [lcar_pkg::BITC_W-1:0]         n_bitc;
    logic [lcar_pkg::SAMPLE_BITS-1:0]    n_shift;
    logic [lcar_pkg::SUM_W-1:0]          n_sum;
    logic [lcar_pkg::CNT_W-1:0]          n_cnt;
    logic [lcar_pkg::TMO_W-1:0]          n_wait;
    logic                                n_doing_tare;

    logic                                w_accept;
    logic [1:0]                          w_mode;
    logic                                w_d;
    logic                                w_clk;
    logic                                w_tmo;
    logic                                w_wt;
    logic                                w_finish;
    logic [lcar_pkg::CNT_W-1:0]          w_target;
    logic [lcar_pkg::SUM_W-1:0]          w_sample;
    logic [lcar_pkg::NET_W-1:0]          w_net;

    lcar_pkg::t_div_req                  w_div_req;
    lcar_pkg::t_div_rsp                  w_div_rsp;

    assign s_axis_tready = !r_div_busy && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = s_axis_tuser[1:0];
    assign w_d           = s_axis_tdata[0];

    always_comb begin
        n_phase      = r_phase;
        n_bitc       = r_bitc;
        n_shift      = r_shift;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_wait       = r_wait;
        n_doing_tare = r_doing_tare;
        w_clk        = 1'b0;
        w_tmo        = 1'b0;
        w_wt         = 1'b0;
        w_finish     = 1'b0;
        w_target     = r_doing_tare ? r_tare_samples : r_meas_samples;
        w_sample     = '0;
        case (r_phase)
            PH_IDLE: begin
                if (w_mode == lcar_pkg::MODE_TARE || w_mode == lcar_pkg::MODE_MEASURE) begin
                    n_doing_tare = (w_mode == lcar_pkg::MODE_TARE);
                    n_sum        = '0;
                    n_cnt        = '0;
                    n_wait       = '0;
                    n_bitc       = '0;
                    n_shift      = '0;
                    n_phase      = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!w_d) begin
                    w_clk   = 1'b1;
                    n_bitc  = '0;
                    n_shift = '0;
                    n_phase = PH_SAMPLE;
                end else begin
                    n_wait = r_wait + 1'b1;
                    if (n_wait >= r_timeout || n_wait == '0) begin
                        w_tmo   = 1'b1;
                        w_wt    = r_doing_tare;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_HIGH: begin
                w_clk   = 1'b1;
                n_phase = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                n_shift = {r_shift[lcar_pkg::SAMPLE_BITS-2:0], w_d};
                n_bitc  = r_bitc + 1'b1;
                if (n_bitc >= lcar_pkg::BITC_W'(lcar_pkg::SAMPLE_BITS)) begin
                    w_sample = {{(lcar_pkg::SUM_W - lcar_pkg::SAMPLE_BITS)
                                 {n_shift[lcar_pkg::SAMPLE_BITS-1]}}, n_shift};
                    n_sum    = r_sum + w_sample;
                    n_cnt    = r_cnt + 1'b1;
                    n_bitc   = '0;
                    if (n_cnt >= w_target || n_cnt == '0) begin
                        w_finish = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_wait  = '0;
                        n_phase = PH_WAIT;
                    end
                end else begin
                    n_phase = PH_HIGH;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign w_div_req.start    = w_accept && w_finish;
    assign w_div_req.dividend = n_sum;
    assign w_div_req.divisor  = {n_cnt == '0, n_cnt};

    lcar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_net = {w_div_rsp.quotient[lcar_pkg::AVG_W-1], w_div_rsp.quotient}
                 - {r_tare[lcar_pkg::AVG_W-1], r_tare};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bitc         <= '0;
            r_shift        <= '0;
            r_sum          <= '0;
            r_cnt          <= '0;
            r_wait         <= '0;
            r_tare         <= '0;
            r_doing_tare   <= 1'b0;
            r_div_busy     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_tare_samples <= lcar_pkg::TARE_SAMPLES_RST;
            r_meas_samples <= lcar_pkg::MEASURE_SAMPLES_RST;
            r_timeout      <= lcar_pkg::READY_TIMEOUT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lcar_pkg::CFG_TARE_SAMPLES:
                        r_tare_samples <= i_cfg_wdata[lcar_pkg::CNT_W-1:0];
                    lcar_pkg::CFG_MEASURE_SAMPLES:
                        r_meas_samples <= i_cfg_wdata[lcar_pkg::CNT_W-1:0];
                    lcar_pkg::CFG_READY_TIMEOUT:
                        r_timeout <= i_cfg_wdata[lcar_pkg::TMO_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_accept) begin
                r_phase      <= n_phase;
                r_bitc       <= n_bitc;
                r_shift      <= n_shift;
                r_sum        <= n_sum;
                r_cnt        <= n_cnt;
                r_wait       <= n_wait;
                r_doing_tare <= n_doing_tare;
            end

            if (w_div_rsp.done) begin
                r_div_busy  <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_user  <= r_doing_tare;
                if (r_doing_tare) begin
                    r_tare     <= w_div_rsp.quotient;
                    r_out_data <= {3'b000, {lcar_pkg::NET_W{1'b0}}, w_div_rsp.quotient,
                                   1'b0, 1'b1, 1'b0, 1'b0};
                end else begin
                    r_out_data <= {3'b000, w_net, w_div_rsp.quotient,
                                   1'b0, 1'b1, 1'b0, 1'b0};
                end
            end else if (w_accept && w_finish) begin
                r_div_busy  <= 1'b1;
                r_out_valid <= 1'b0;
            end else if (w_accept) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {3'b000, {lcar_pkg::NET_W{1'b0}}, {lcar_pkg::AVG_W{1'b0}},
                                w_tmo, 1'b0, n_phase != PH_IDLE, w_clk};
                r_out_user  <= w_wt;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
